// ----- rtl/ppes_pkg.sv -----
// ----------------------------------------------------------------------------
// ppes_pkg
// Widths and defaults shared by the pulse statistics block and its checker.
// ----------------------------------------------------------------------------
package ppes_pkg;

  localparam int SAMPLE_BITS     = 16;    // sample word, two's complement
  localparam int MAX_SAMPLES_DEF = 4096;  // default store depth
  localparam int ONSET_W         = 32;
  localparam int DUR_W           = 13;    // duration field
  localparam int OFS_W           = 12;    // offset fields

endpackage

// ----- rtl/ppes_ram.sv -----
// ----------------------------------------------------------------------------
// ppes_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pulse_peak_energy_stats.sv -----
// ----------------------------------------------------------------------------
// pulse_peak_energy_stats
// Per-pulse duration, peaks and 5% / 95% energy offsets.
// ----------------------------------------------------------------------------
// Use: drive one sample of a pulse with start while busy is low; the beat is
// taken on that edge. first opens a new pulse (count, peaks, energy and the
// truncation flag are cleared, onset_time is captured); last closes it.
// Samples past MAX_SAMPLES are dropped and set truncated.
// Each sample passes through capture, square and accumulate, with busy high
// for the square and accumulate steps. On a last sample the block then scans
// the sample store forwards and backwards; each scan step is a RAM read, a
// square, an accumulate and a threshold compare, and the two scans cover at
// most N + 1 steps for an N-sample pulse. The squarer is one shared unit,
// used for both ingest and scans. The record appears for one cycle with done
// high; the receiver cannot stall, and a new sample may be started in that
// cycle. Synchronous reset returns to idle with count, peaks, energy and onset
// cleared; the sample store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pulse_peak_energy_stats import ppes_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          first,
  input  logic                          last,
  input  logic [ONSET_W-1:0]            onset_time,
  output logic                          done,
  output logic [ONSET_W-1:0]            onset,
  output logic [DUR_W-1:0]              duration,
  output logic [SAMPLE_BITS-2:0]        peak_pos,
  output logic signed [SAMPLE_BITS-1:0] peak_neg,
  output logic [OFS_W-1:0]              peak_pos_at,
  output logic [OFS_W-1:0]              peak_neg_at,
  output logic [OFS_W-1:0]              start_5pct,
  output logic [OFS_W-1:0]              end_95pct,
  output logic                          truncated
);

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int EN_W   = SQ_W + CNT_W;
  localparam int CMP_W  = EN_W + 5;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  typedef enum logic [2:0] {
    S_IDLE, S_TAKE, S_ACC, S_RD, S_SQ, S_ADD, S_CMP
  } state_t;

  state_t                   state;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic                     last_reg;
  logic                     kept;
  logic [CNT_W-1:0]         count;
  logic signed [SAMPLE_BITS-1:0] peak_high;
  logic signed [SAMPLE_BITS-1:0] peak_low;
  logic [ADDR_W-1:0]        peak_high_at;
  logic [ADDR_W-1:0]        peak_low_at;
  logic [EN_W-1:0]          total;
  logic [ONSET_W-1:0]       onset_hold;
  logic                     overflow;
  logic [SQ_W-1:0]          e_reg;
  logic [EN_W-1:0]          cum;
  logic [ADDR_W-1:0]        idx;
  logic [ADDR_W-1:0]        start5;
  logic                     fwd;

  logic                     we;
  logic [SAMPLE_BITS-1:0]   rdata;
  logic signed [SAMPLE_BITS-1:0]   sq_in;
  logic signed [2*SAMPLE_BITS-1:0] sq_prod;
  logic [CMP_W-1:0]         cum20;
  logic [CMP_W-1:0]         tot_ext;
  logic [CNT_W:0]           idx_p1;
  logic                     fwd_more;
  logic [CNT_W-1:0]         cnt_m1;
  logic [CNT_W+DUR_W-1:0]   dur_w;
  logic [ADDR_W+OFS_W-1:0]  pha_w;
  logic [ADDR_W+OFS_W-1:0]  pla_w;
  logic [ADDR_W+OFS_W-1:0]  s5_w;
  logic [ADDR_W+OFS_W-1:0]  e95_w;

  assign busy = (state != S_IDLE);
  assign we   = (state == S_TAKE) && (count < MAX_CNT);

  ppes_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (x_reg),
    .raddr (idx),
    .rdata (rdata)
  );

  // shared squarer: incoming sample on ingest, stored sample on scans
  assign sq_in   = (state == S_TAKE) ? x_reg : $signed(rdata);
  assign sq_prod = sq_in * sq_in;

  // exact 20*cum against total
  assign cum20   = ({5'b0, cum} << 4) + ({5'b0, cum} << 2);
  assign tot_ext = {5'b0, total};

  assign idx_p1   = {{(CNT_W + 1 - ADDR_W){1'b0}}, idx} + 1'b1;
  assign fwd_more = idx_p1 < {1'b0, count};
  assign cnt_m1   = count - 1'b1;

  assign dur_w = {{DUR_W{1'b0}}, count};
  assign pha_w = {{OFS_W{1'b0}}, peak_high_at};
  assign pla_w = {{OFS_W{1'b0}}, peak_low_at};
  assign s5_w  = {{OFS_W{1'b0}}, start5};
  assign e95_w = {{OFS_W{1'b0}}, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      count        <= '0;
      peak_high    <= '0;
      peak_low     <= '0;
      peak_high_at <= '0;
      peak_low_at  <= '0;
      total        <= '0;
      onset_hold   <= '0;
      overflow     <= 1'b0;
      fwd          <= 1'b0;
      kept         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            x_reg    <= sample;
            last_reg <= last;
            if (first) begin
              count        <= '0;
              peak_high    <= '0;
              peak_low     <= '0;
              peak_high_at <= '0;
              peak_low_at  <= '0;
              total        <= '0;
              overflow     <= 1'b0;
              onset_hold   <= onset_time;
            end
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          e_reg <= sq_prod[SQ_W-1:0];
          if (count < MAX_CNT) begin
            kept <= 1'b1;
            // negative peak only tested when the positive one does not move
            if (x_reg > peak_high) begin
              peak_high    <= x_reg;
              peak_high_at <= count[ADDR_W-1:0];
            end else if (x_reg < peak_low) begin
              peak_low    <= x_reg;
              peak_low_at <= count[ADDR_W-1:0];
            end
            count <= count + 1'b1;
          end else begin
            kept     <= 1'b0;
            overflow <= 1'b1;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          if (kept) begin
            total <= total + EN_W'(e_reg);
          end
          if (!last_reg) begin
            state <= S_IDLE;
          end else if (count == '0) begin
            onset       <= onset_hold;
            duration    <= '0;
            peak_pos    <= peak_high[SAMPLE_BITS-2:0];
            peak_neg    <= peak_low;
            peak_pos_at <= pha_w[OFS_W-1:0];
            peak_neg_at <= pla_w[OFS_W-1:0];
            start_5pct  <= '0;
            end_95pct   <= '0;
            truncated   <= overflow;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            idx   <= '0;
            cum   <= '0;
            fwd   <= 1'b1;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_SQ;
        end
        S_SQ: begin
          e_reg <= sq_prod[SQ_W-1:0];
          state <= S_ADD;
        end
        S_ADD: begin
          cum   <= cum + EN_W'(e_reg);
          state <= S_CMP;
        end
        S_CMP: begin
          if (fwd) begin
            if (fwd_more && (cum20 <= tot_ext)) begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end else begin
              // forward done: backward scan from the last stored sample
              start5 <= idx;
              idx    <= cnt_m1[ADDR_W-1:0];
              cum    <= '0;
              fwd    <= 1'b0;
              state  <= S_RD;
            end
          end else begin
            if ((idx != '0) && (cum20 < tot_ext)) begin
              idx   <= idx - 1'b1;
              state <= S_RD;
            end else begin
              onset       <= onset_hold;
              duration    <= dur_w[DUR_W-1:0];
              peak_pos    <= peak_high[SAMPLE_BITS-2:0];
              peak_neg    <= peak_low;
              peak_pos_at <= pha_w[OFS_W-1:0];
              peak_neg_at <= pla_w[OFS_W-1:0];
              start_5pct  <= s5_w[OFS_W-1:0];
              end_95pct   <= e95_w[OFS_W-1:0];
              truncated   <= overflow;
              done        <= 1'b1;
              state       <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ppes_checker.sv -----
// ----------------------------------------------------------------------------
// ppes_checker
// Port-level checks on the pulse statistics block, bound into every instance of it.
// ----------------------------------------------------------------------------
module ppes_checker import ppes_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // a taken beat always keeps the block working for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("busy not held after an accepted beat");

  // records only leave once the block has gone back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a start");

endmodule

bind pulse_peak_energy_stats ppes_checker u_ppes_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pulse_peak_energy_stats. Pulses of samples are
// driven as command beats (start / busy) with random idle gaps. A scoreboard
// predicts each statistics record, including the peaks, the 5% and 95% energy
// offsets and the truncation flag, and compares every done strobe with it.
// ----------------------------------------------------------------------------
module testbench;
  import ppes_pkg::*;

  typedef struct {
    logic [ONSET_W-1:0]            onset;
    logic [DUR_W-1:0]              duration;
    logic [SAMPLE_BITS-2:0]        peak_pos;
    logic signed [SAMPLE_BITS-1:0] peak_neg;
    logic [OFS_W-1:0]              peak_pos_at;
    logic [OFS_W-1:0]              peak_neg_at;
    logic [OFS_W-1:0]              start_5pct;
    logic [OFS_W-1:0]              end_95pct;
    logic                          truncated;
  } pulse_rec_t;

  typedef enum int {
    SHAPE_FULL,
    SHAPE_SMALL,
    SHAPE_ZERO,
    SHAPE_EDGE,
    SHAPE_SPIKE
  } shape_t;

  class pulse_scoreboard;
    logic signed [SAMPLE_BITS-1:0] store [MAX_SAMPLES_DEF];
    int                            count;
    logic signed [SAMPLE_BITS-1:0] pk_hi, pk_lo;
    int                            hi_at, lo_at;
    longint unsigned               energy;
    logic [ONSET_W-1:0]            onset_hold;
    bit                            overflow;
    pulse_rec_t                    stats_q [$];
    int                            errors, n_samples, n_dropped, n_records, n_quiet;

    function new();
      errors = 0;
      n_samples = 0;
      n_dropped = 0;
      n_records = 0;
      n_quiet = 0;
      open_pulse('0);
    endfunction

    function void open_pulse(logic [ONSET_W-1:0] t);
      count = 0;
      pk_hi = '0;
      pk_lo = '0;
      hi_at = 0;
      lo_at = 0;
      energy = 0;
      overflow = 1'b0;
      onset_hold = t;
    endfunction

    function longint unsigned sq(logic signed [SAMPLE_BITS-1:0] x);
      longint w;
      w = x;
      return longint'(w * w);
    endfunction

    // one accepted beat; a last beat queues the record it will produce
    function void take_sample(logic signed [SAMPLE_BITS-1:0] x, bit f, bit l,
                              logic [ONSET_W-1:0] t);
      pulse_rec_t      rec;
      longint unsigned cum;
      int              fwd, bwd;
      n_samples++;
      if (f) open_pulse(t);
      if (count < MAX_SAMPLES_DEF) begin
        store[count] = x;
        if (x > pk_hi) begin
          pk_hi = x;
          hi_at = count;
        end else if (x < pk_lo) begin
          pk_lo = x;
          lo_at = count;
        end
        energy += sq(x);
        count++;
      end else begin
        overflow = 1'b1;
        n_dropped++;
      end
      if (!l) return;
      fwd = 0;
      bwd = 0;
      if (count > 0) begin
        cum = sq(store[0]);
        while (fwd + 1 < count && cum * 20 <= energy) begin
          fwd++;
          cum += sq(store[fwd]);
        end
        bwd = count - 1;
        cum = sq(store[bwd]);
        while (bwd > 0 && cum * 20 < energy) begin
          bwd--;
          cum += sq(store[bwd]);
        end
      end
      if (energy == 0) n_quiet++;
      rec.onset       = onset_hold;
      rec.duration    = count[DUR_W-1:0];
      rec.peak_pos    = pk_hi[SAMPLE_BITS-2:0];
      rec.peak_neg    = pk_lo;
      rec.peak_pos_at = hi_at[OFS_W-1:0];
      rec.peak_neg_at = lo_at[OFS_W-1:0];
      rec.start_5pct  = fwd[OFS_W-1:0];
      rec.end_95pct   = bwd[OFS_W-1:0];
      rec.truncated   = overflow;
      stats_q.push_back(rec);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_record(pulse_rec_t got);
      pulse_rec_t want;
      if (stats_q.size() == 0) begin
        $display("%0t: record with none expected, onset %0d duration %0d",
                 $time, got.onset, got.duration);
        errors++;
        return;
      end
      want = stats_q.pop_front();
      n_records++;
      cmp("onset",       want.onset,       got.onset);
      cmp("duration",    want.duration,    got.duration);
      cmp("peak_pos",    want.peak_pos,    got.peak_pos);
      cmp("peak_neg",    want.peak_neg,    got.peak_neg);
      cmp("peak_pos_at", want.peak_pos_at, got.peak_pos_at);
      cmp("peak_neg_at", want.peak_neg_at, got.peak_neg_at);
      cmp("start_5pct",  want.start_5pct,  got.start_5pct);
      cmp("end_95pct",   want.end_95pct,   got.end_95pct);
      cmp("truncated",   want.truncated,   got.truncated);
    endfunction

    function int pending();
      return stats_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          first = 1'b0;
  logic                          last = 1'b0;
  logic [ONSET_W-1:0]            onset_time = '0;
  logic                          busy, done, truncated;
  logic [ONSET_W-1:0]            onset;
  logic [DUR_W-1:0]              duration;
  logic [SAMPLE_BITS-2:0]        peak_pos;
  logic signed [SAMPLE_BITS-1:0] peak_neg;
  logic [OFS_W-1:0]              peak_pos_at, peak_neg_at, start_5pct, end_95pct;

  pulse_scoreboard sb = new();
  int              items_sent = 0;

  pulse_peak_energy_stats i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample      (sample),
    .first       (first),
    .last        (last),
    .onset_time  (onset_time),
    .done        (done),
    .onset       (onset),
    .duration    (duration),
    .peak_pos    (peak_pos),
    .peak_neg    (peak_neg),
    .peak_pos_at (peak_pos_at),
    .peak_neg_at (peak_neg_at),
    .start_5pct  (start_5pct),
    .end_95pct   (end_95pct),
    .truncated   (truncated)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    pulse_rec_t got;
    if (!rst && done) begin
      got.onset       = onset;
      got.duration    = duration;
      got.peak_pos    = peak_pos;
      got.peak_neg    = peak_neg;
      got.peak_pos_at = peak_pos_at;
      got.peak_neg_at = peak_neg_at;
      got.start_5pct  = start_5pct;
      got.end_95pct   = end_95pct;
      got.truncated   = truncated;
      sb.check_record(got);
    end
  end

  function int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function int pulse_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(24, 1);
    if (r < 97) return $urandom_range(200, 25);
    return $urandom_range(600, 201);
  endfunction

  function logic signed [SAMPLE_BITS-1:0] pick_sample(shape_t shape, int idx, int spike);
    int v;
    case (shape)
      SHAPE_FULL:  v = $urandom_range(65535);
      SHAPE_SMALL: v = int'($urandom_range(16)) - 8;
      SHAPE_ZERO:  v = 0;
      SHAPE_EDGE: begin
        case ($urandom_range(4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = -1;
          3:       v = 1;
          default: v = 0;
        endcase
      end
      default: v = (idx == spike) ? int'($urandom_range(65535))
                                  : int'($urandom_range(4)) - 2;
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // one beat, held until taken, then an optional idle gap
  task automatic send_beat(logic signed [SAMPLE_BITS-1:0] s, bit f, bit l,
                           logic [ONSET_W-1:0] t, bit quiet);
    int g;
    start      <= 1'b1;
    sample     <= s;
    first      <= f;
    last       <= l;
    onset_time <= t;
    do @(posedge clk); while (busy);
    sb.take_sample(s, f, l, t);
    items_sent++;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic run_pulse(int len, shape_t shape, bit with_first, bit with_last, bit quiet);
    int spike;
    spike = $urandom_range(len - 1);
    for (int i = 0; i < len; i++)
      send_beat(pick_sample(shape, i, spike), with_first && i == 0,
                with_last && i == len - 1, $urandom(), quiet);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int     base, r, len;
    shape_t shape;
    bit     quiet;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // no first after reset, then a continuation after the record
    send_beat(16'sd100, 0, 0, 32'h1234_5678, 0);
    send_beat(-16'sd200, 0, 1, 32'h0, 0);
    send_beat(16'sd300, 0, 1, 32'hDEAD_BEEF, 0);
    // one-sample pulses at the extremes
    send_beat(16'sd32767, 1, 1, 32'hFFFF_FFFF, 0);
    send_beat(-16'sd32768, 1, 1, 32'h0, 0);
    send_beat(16'sd0, 1, 1, 32'hA5A5_A5A5, 0);
    // all-zero pulse: forward scan runs to the end
    send_beat(16'sd0, 1, 0, 32'h5A5A_5A5A, 0);
    send_beat(16'sd0, 0, 0, 32'h0, 0);
    send_beat(16'sd0, 0, 0, 32'h0, 0);
    send_beat(16'sd0, 0, 1, 32'h0, 0);
    // equal peaks keep the earlier offset
    send_beat(16'sd5, 1, 0, 32'h0000_0001, 0);
    send_beat(16'sd5, 0, 0, 32'h0, 0);
    send_beat(-16'sd7, 0, 0, 32'h0, 0);
    send_beat(-16'sd7, 0, 0, 32'h0, 0);
    send_beat(16'sd7, 0, 1, 32'h0, 0);
    // first in mid-pulse abandons the open one
    send_beat(16'sd9, 1, 0, 32'h0000_0010, 0);
    send_beat(-16'sd9, 1, 0, 32'h0000_0020, 0);
    send_beat(16'sd1, 0, 1, 32'h0, 0);
    // lone burst of energy in the middle
    send_beat(16'sd0, 1, 0, 32'h8000_0000, 0);
    send_beat(16'sd0, 0, 0, 32'h0, 0);
    send_beat(16'sd1000, 0, 0, 32'h0, 0);
    send_beat(16'sd0, 0, 0, 32'h0, 0);
    send_beat(16'sd0, 0, 1, 32'h0, 0);
    drain();

    base = items_sent;
    while (items_sent < 1300) begin
      r     = $urandom_range(99);
      len   = pulse_len();
      shape = shape_t'($urandom_range(SHAPE_SPIKE));
      quiet = ($urandom_range(9) < 2);
      if (r < 78 || items_sent == base)
        run_pulse(len, shape, 1, 1, quiet);
      else if (r < 86)
        run_pulse(len, shape, 0, 1, quiet);
      else if (r < 92)
        run_pulse(len, shape, 1, 0, quiet);
      else
        repeat (len % 8 + 1)
          send_beat(SAMPLE_BITS'($urandom()), 1'($urandom_range(1)),
                    1'($urandom_range(1)), $urandom(), quiet);
      if ($urandom_range(49) == 0) drain();
    end

    drain();
    // room for any stray record from a full-length scan
    repeat (4 * MAX_SAMPLES_DEF + 16) @(posedge clk);
    $display("covered %0d beats (%0d dropped past capacity), %0d records checked",
             sb.n_samples, sb.n_dropped, sb.n_records);
    $display("records from all-zero pulses: %0d, mismatches: %0d", sb.n_quiet, sb.errors);
    if (sb.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ppes_pkg.sv
rtl/ppes_ram.sv
rtl/pulse_peak_energy_stats.sv
rtl/ppes_checker.sv
dv/testbench.sv
